/* rtl/core/metropolis_ring_lattice_update_core_macros.svh */
// Assertion macros used by the checker.
`ifndef METROPOLIS_RING_LATTICE_UPDATE_CORE_MACROS_SVH
`define METROPOLIS_RING_LATTICE_UPDATE_CORE_MACROS_SVH

// Same-cycle implication.
`define MRLU_AST_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mrlu assertion failed");

// Next-cycle implication.
`define MRLU_AST_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mrlu assertion failed");

`endif

/* rtl/core/mrlu_pkg.sv */
package mrlu_pkg;

	localparam int SITES_DEF = 1024;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [23:0] COEFF_RST = 24'd65536;
	localparam logic [23:0] STEP_RST = 24'd65536;
	localparam logic [10:0] LEN_RST = 11'd1024;
	localparam logic [10:0] LEN_MIN = 11'd2;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic signed [55:0] DS_LIMIT = 56'sd786432;
	localparam logic signed [55:0] SAT_HI = 56'sd2147483647;
	localparam logic signed [55:0] SAT_LO = -56'sd2147483648;
	localparam int DIV_NUM_W = 38;
	localparam int DIV_DEN_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KINETIC,
		CFG_POTENTIAL,
		CFG_STEP,
		CFG_LEN
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_X,
		ST_RD_N,
		ST_RD_P,
		ST_SUM,
		ST_MUL_A,
		ST_INNER,
		ST_MUL_D,
		ST_DS,
		ST_EXP_Y,
		ST_EXP_T,
		ST_DECIDE,
		ST_SCALE,
		ST_DIV_GO,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic [9:0] site_index;
		logic signed [15:0] proposal;
		logic [15:0] accept_draw;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic signed [31:0] new_value;
		logic signed [31:0] action_change;
		logic signed [47:0] running_action;
		logic [23:0] step_size;
		logic sweep_end;
	} res_t;

	function automatic logic [16:0] exp2_tab(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0: v = 17'd65536;
			5'd1: v = 17'd62757;
			5'd2: v = 17'd60097;
			5'd3: v = 17'd57549;
			5'd4: v = 17'd55109;
			5'd5: v = 17'd52773;
			5'd6: v = 17'd50535;
			5'd7: v = 17'd48393;
			5'd8: v = 17'd46341;
			5'd9: v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/mrlu_site_mem.sv */
module mrlu_site_mem import mrlu_pkg::*; #(
	parameter int SITES = SITES_DEF,
	parameter int AW = $clog2(SITES)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic signed [31:0] wdata,
	input logic [AW-1:0] raddr,
	output logic signed [31:0] rdata
);

	logic signed [31:0] mem [SITES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/mrlu_step_div.sv */
module mrlu_step_div import mrlu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [DIV_NUM_W-1:0] dividend,
	input logic [DIV_DEN_W-1:0] divisor,
	output logic done,
	output logic [DIV_NUM_W-1:0] quotient
);

	localparam int CW = $clog2(DIV_NUM_W);
	localparam logic [CW-1:0] LAST = CW'(DIV_NUM_W - 1);

	logic run_q;
	logic [CW-1:0] cnt_q;
	logic [DIV_DEN_W:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0] rem_sh;
	logic [DIV_DEN_W+1:0] diff;

	assign rem_sh = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
	assign diff = {1'b0, rem_sh} - {2'b00, divisor};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= run_q && (cnt_q == LAST);
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			if (!diff[DIV_DEN_W+1]) begin
				rem_q <= diff[DIV_DEN_W:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/core/metropolis_ring_lattice_update_core.sv */
// Metropolis update engine for a ring lattice of harmonic-oscillator path sites.
// Request channel: drive req and raise start; the request is taken at a rising
// edge where start is high and busy is low. One request is worked at a time.
// Result channel: done pulses for one cycle with res valid; there is no back
// pressure, so capture res on that cycle.
// Sequence: a taken request runs RD_X, RD_N, RD_P, SUM, MUL_A, INNER, MUL_D,
// DS, EXP_Y, EXP_T and DECIDE before done; a new request can be taken at the
// edge that ends the done cycle. Three site-memory reads (one read port) and the
// chained multiply, floor and exp-table steps set the path; closing a sweep adds
// SCALE, DIV_GO and a bit-serial step rescale in DIV (one quotient bit per cycle).
// Configuration: cfg_we writes cfg_data to register cfg_idx at once; write only
// while busy is low. Writing CFG_STEP loads the live step size directly.
// Reset: arst_n clears control state, then the block sweeps the site memory to
// zero, one site per cycle through all SITES sites, holding busy high meanwhile.
module metropolis_ring_lattice_update_core import mrlu_pkg::*; #(
	parameter int SITES = SITES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input req_t req,
	output logic done,
	output res_t res,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(SITES);
	localparam logic [16:0] SITES_W = 17'(SITES);
	localparam logic [AW-1:0] CLR_LAST = AW'(SITES - 1);

	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [23:0] kin_q, pot_q, step_q;
	logic [10:0] len_q, upd_q, accs_q;
	logic signed [47:0] acc_q;
	logic done_q;

	req_t req_q;
	logic [AW-1:0] idx_q, nxt_q, prv_q;
	logic signed [23:0] dx_q;
	logic signed [31:0] x_q, xn_q;
	logic signed [35:0] t1_q;
	logic signed [34:0] t2_q;
	logic signed [60:0] pa_q;
	logic signed [59:0] pb_q;
	logic signed [61:0] inner_q;
	logic signed [52:0] ph_q;
	logic signed [57:0] pl_q;
	logic signed [55:0] ds_q;
	logic neg_q, big_q;
	logic [20:0] y_q;
	logic [16:0] ti_q;
	logic [23:0] dd_q;
	logic [4:0] k_q;
	logic [10:0] accs_fin_q;
	logic [34:0] prod_q;
	res_t res_q;

	logic [10:0] len_use, idx_c, nxt_c, prv_c, last_c;
	logic [AW-1:0] raddr, waddr;
	logic we;
	logic signed [31:0] wdata, rdata;
	logic signed [40:0] dxp_c;
	logic [16:0] v_c, e_c;
	logic take_c, sweep_c;
	logic signed [31:0] newv_c, applied_c;
	logic [11:0] upd_inc;
	logic [10:0] accs_inc;
	logic div_go, div_done;
	logic [DIV_NUM_W-1:0] quo;
	logic [23:0] step_new_c;

	always_comb begin
		if (len_q < LEN_MIN) begin
			len_use = LEN_MIN;
		end else if (17'(len_q) > SITES_W) begin
			len_use = 11'(SITES_W);
		end else begin
			len_use = len_q;
		end
		last_c = len_use - 11'd1;
		idx_c = ({1'b0, req.site_index} >= len_use) ? last_c : {1'b0, req.site_index};
		nxt_c = (idx_c == last_c) ? 11'd0 : idx_c + 11'd1;
		prv_c = (idx_c == 11'd0) ? last_c : idx_c - 11'd1;
	end

	assign dxp_c = 41'(req_q.proposal) * 41'($signed({1'b0, step_q}));
	assign v_c = ti_q - 17'(dd_q >> 12);
	assign e_c = v_c >> k_q;
	assign take_c = neg_q | (!big_q && ({1'b0, req_q.accept_draw} < e_c));
	assign newv_c = take_c ? sat32(56'(33'(x_q) + 33'(dx_q))) : x_q;
	assign applied_c = take_c ? sat32(ds_q) : 32'sd0;
	assign upd_inc = {1'b0, upd_q} + 12'd1;
	assign sweep_c = upd_inc >= {1'b0, len_use};
	assign accs_inc = accs_q + {10'd0, take_c};
	assign step_new_c = (|quo[DIV_NUM_W-1:24]) ? 24'hffffff : quo[23:0];

	always_comb begin
		case (state_q)
			ST_RD_X: raddr = idx_q;
			ST_RD_N: raddr = nxt_q;
			default: raddr = prv_q;
		endcase
		we = (state_q == ST_CLEAR) || ((state_q == ST_DECIDE) && take_c);
		waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
		wdata = (state_q == ST_CLEAR) ? 32'sd0 : newv_c;
	end

	mrlu_site_mem #(.SITES(SITES), .AW(AW)) u_mem (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mrlu_step_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.dividend((38'(prod_q) << 2) + 38'(prod_q)),
		.divisor({len_use, 2'b00}),
		.done(div_done),
		.quotient(quo)
	);

	always_comb begin
		state_d = state_q;
		div_go = 1'b0;
		case (state_q)
			ST_CLEAR: if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_RD_X;
			ST_RD_X: state_d = ST_RD_N;
			ST_RD_N: state_d = ST_RD_P;
			ST_RD_P: state_d = ST_SUM;
			ST_SUM: state_d = ST_MUL_A;
			ST_MUL_A: state_d = ST_INNER;
			ST_INNER: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_DS;
			ST_DS: state_d = ST_EXP_Y;
			ST_EXP_Y: state_d = ST_EXP_T;
			ST_EXP_T: state_d = ST_DECIDE;
			ST_DECIDE: state_d = sweep_c ? ST_SCALE : ST_IDLE;
			ST_SCALE: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_go = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: if (div_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			kin_q <= COEFF_RST;
			pot_q <= COEFF_RST;
			step_q <= STEP_RST;
			len_q <= LEN_RST;
			upd_q <= '0;
			accs_q <= '0;
			acc_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= ((state_q == ST_DECIDE) && !sweep_c) || ((state_q == ST_DIV) && div_done);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					CFG_KINETIC: kin_q <= cfg_data;
					CFG_POTENTIAL: pot_q <= cfg_data;
					CFG_STEP: step_q <= cfg_data;
					CFG_LEN: len_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (state_q == ST_DECIDE) begin
				acc_q <= acc_q + 48'(applied_c);
				if (sweep_c) begin
					upd_q <= '0;
					accs_q <= '0;
				end else begin
					upd_q <= upd_inc[10:0];
					accs_q <= accs_inc;
				end
			end
			if ((state_q == ST_DIV) && div_done) begin
				step_q <= step_new_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req;
				idx_q <= AW'(idx_c);
				nxt_q <= AW'(nxt_c);
				prv_q <= AW'(prv_c);
			end
			ST_RD_X: dx_q <= dxp_c[39:16];
			ST_RD_N: x_q <= rdata;
			ST_RD_P: xn_q <= rdata;
			ST_SUM: begin
				t1_q <= (36'(x_q) <<< 1) + 36'(dx_q) - 36'(xn_q) - 36'(rdata);
				t2_q <= (35'(x_q) <<< 1) + 35'(dx_q);
			end
			ST_MUL_A: begin
				pa_q <= 61'($signed({1'b0, kin_q})) * 61'(t1_q);
				pb_q <= 60'($signed({1'b0, pot_q})) * 60'(t2_q);
			end
			ST_INNER: inner_q <= (62'(pa_q) <<< 1) + 62'(pb_q);
			ST_MUL_D: begin
				ph_q <= 53'(dx_q) * 53'($signed(inner_q[61:33]));
				pl_q <= 58'(dx_q) * 58'($signed({1'b0, inner_q[32:0]}));
			end
			ST_DS: ds_q <= 56'(ph_q) + 56'($signed(pl_q[57:33]));
			ST_EXP_Y: begin
				neg_q <= ds_q < 56'sd0;
				big_q <= ds_q >= DS_LIMIT;
				y_q <= 21'(({17'd0, ds_q[19:0]} * {20'd0, LOG2E_Q16}) >> 16);
			end
			ST_EXP_T: begin
				ti_q <= exp2_tab({1'b0, y_q[15:12]});
				dd_q <= ({7'd0, exp2_tab({1'b0, y_q[15:12]})}
					- {7'd0, exp2_tab({1'b0, y_q[15:12]} + 5'd1)}) * {12'd0, y_q[11:0]};
				k_q <= y_q[20:16];
			end
			ST_DECIDE: begin
				res_q.accepted <= take_c;
				res_q.new_value <= newv_c;
				res_q.action_change <= applied_c;
				res_q.running_action <= acc_q + 48'(applied_c);
				res_q.step_size <= step_q;
				res_q.sweep_end <= sweep_c;
				accs_fin_q <= accs_inc;
			end
			ST_SCALE: prod_q <= 35'(step_q) * 35'(accs_fin_q);
			ST_DIV: if (div_done) res_q.step_size <= step_new_c;
			default: ;
		endcase
	end

endmodule

/* rtl/core/mrlu_checker.sv */
`include "metropolis_ring_lattice_update_core_macros.svh"

module mrlu_checker import mrlu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t res
);

	`MRLU_AST_NXT(a_take_sets_busy, clk, arst_n, start && !busy, busy)
	`MRLU_AST_NXT(a_done_single, clk, arst_n, done, !done)
	`MRLU_AST_IMP(a_reject_no_change, clk, arst_n, done && !res.accepted, res.action_change == 32'sd0)
	`MRLU_AST_IMP(a_done_after_work, clk, arst_n, done, $past(busy))

endmodule

bind metropolis_ring_lattice_update_core mrlu_checker u_mrlu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.res(res)
);

/* tb/sv/metropolis_ring_lattice_update_core_tb.sv */
module metropolis_ring_lattice_update_core_tb;
	import mrlu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSITES = 1024;
	localparam int N_RANDOM = 1800;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t res;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	metropolis_ring_lattice_update_core #(.SITES(NSITES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	logic signed [31:0] lat[NSITES];
	logic [23:0] alpha_q, beta_q, step0_q, step_q;
	logic [10:0] len_q;
	logic [47:0] acc_q;
	int unsigned upd_cnt, acc_cnt;
	res_t pending_results[$];
	int errors;
	int n_sent, n_checked, n_sweeps, n_taken;

	localparam logic [16:0] EXP_TAB[17] = '{65536, 62757, 60097, 57549, 55109,
		52773, 50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734,
		34219, 32768};

	function automatic logic signed [127:0] fshift(input logic signed [127:0] v, input int k);
		return v >>> k;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [16:0] exp_limit(input logic signed [127:0] ds);
		logic signed [127:0] y;
		logic [31:0] k;
		logic [15:0] f;
		logic [4:0] i;
		logic [11:0] r;
		logic [16:0] v;
		if (ds >= (128'sd12 <<< 16)) return 17'd0;
		y = (ds * 128'sd94548) >>> 16;
		k = y[47:16];
		f = y[15:0];
		i = {1'b0, f[15:12]};
		r = f[11:0];
		v = EXP_TAB[i] - 17'(((32'(EXP_TAB[i] - EXP_TAB[i+1])) * 32'(r)) >> 12);
		if (k > 31) return 17'd0;
		return v >> k;
	endfunction

	function automatic res_t metropolis_update(input req_t rq);
		res_t o;
		int unsigned len, idx, nxt, prv;
		logic signed [127:0] x, xn, xp, dx, t1, t2, inner, lo, hi, ds;
		logic signed [31:0] applied;
		logic take;
		logic [127:0] s;
		len = (len_q < 2) ? 2 : (len_q > NSITES ? NSITES : len_q);
		idx = rq.site_index;
		if (idx >= len) idx = len - 1;
		nxt = (idx == len - 1) ? 0 : idx + 1;
		prv = (idx == 0) ? len - 1 : idx - 1;
		x = lat[idx];
		xn = lat[nxt];
		xp = lat[prv];
		dx = fshift(128'(rq.proposal) * $signed({104'd0, step_q}), 16);
		t1 = 2 * x + dx - xn - xp;
		t2 = 2 * x + dx;
		inner = 2 * $signed({104'd0, alpha_q}) * t1 + $signed({104'd0, beta_q}) * t2;
		lo = inner & 128'h1FFFFFFFF;
		hi = (inner - lo) >>> 33;
		ds = dx * hi + fshift(dx * lo, 33);
		take = (ds < 0) ? 1'b1 : (rq.accept_draw < exp_limit(ds));
		applied = '0;
		if (take) begin
			lat[idx] = clamp32(x + dx);
			applied = clamp32(ds);
			acc_cnt++;
		end
		acc_q = acc_q + 48'(applied);
		upd_cnt++;
		o.sweep_end = 1'b0;
		if (upd_cnt >= len) begin
			s = (128'(step_q) * acc_cnt * 5) / (4 * len);
			step_q = (s > 128'hFFFFFF) ? 24'hFFFFFF : s[23:0];
			upd_cnt = 0;
			acc_cnt = 0;
			o.sweep_end = 1'b1;
		end
		o.accepted = take;
		o.new_value = lat[idx];
		o.action_change = applied;
		o.running_action = acc_q;
		o.step_size = step_q;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		res_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", res[63:0], 64'd0);
			end else begin
				e = pending_results.pop_front();
				n_checked++;
				if (res.accepted !== e.accepted)
					report_mismatch("accepted", 64'(res.accepted), 64'(e.accepted));
				if (res.new_value !== e.new_value)
					report_mismatch("new_value", 64'(res.new_value), 64'(e.new_value));
				if (res.action_change !== e.action_change)
					report_mismatch("action_change", 64'(res.action_change),
						64'(e.action_change));
				if (res.running_action !== e.running_action)
					report_mismatch("running_action", 64'(res.running_action),
						64'(e.running_action));
				if (res.step_size !== e.step_size)
					report_mismatch("step_size", 64'(res.step_size), 64'(e.step_size));
				if (res.sweep_end !== e.sweep_end)
					report_mismatch("sweep_end", 64'(res.sweep_end), 64'(e.sweep_end));
			end
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
			($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
		if (n != 0) start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(input req_t rq, input logic check_fixed,
			input res_t fixed_res, input logic use_gaps);
		res_t e;
		if (use_gaps) idle_gap();
		start <= 1'b1;
		req <= rq;
		@(posedge clk);
		while (busy) @(posedge clk);
		e = metropolis_update(rq);
		if (check_fixed && e !== fixed_res)
			report_mismatch("table row", e[63:0], fixed_res[63:0]);
		pending_results.insert(pending_results.size(), e);
		n_sent++;
		if (e.sweep_end) n_sweeps++;
		if (e.accepted) n_taken++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [23:0] v);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (r)
			CFG_KINETIC: alpha_q = v;
			CFG_POTENTIAL: beta_q = v;
			CFG_STEP: begin
				step0_q = v;
				step_q = v;
			end
			CFG_LEN: len_q = v[10:0];
			default: ;
		endcase
	endtask

	typedef struct {
		req_t rq;
		logic fixed;
		res_t want;
	} stim_row_t;

	stim_row_t rows[$];

	function automatic void add_row(input req_t rq, input logic fixed, input res_t want);
		stim_row_t r;
		r.rq = rq;
		r.fixed = fixed;
		r.want = want;
		rows.insert(rows.size(), r);
	endfunction

	function automatic req_t mk(input int s, input int p, input int d);
		req_t r;
		r.site_index = 10'(s);
		r.proposal = 16'(p);
		r.accept_draw = 16'(d);
		return r;
	endfunction

	function automatic res_t rz(input logic ac, input logic [23:0] st, input logic sw);
		res_t r;
		r = '0;
		r.accepted = ac;
		r.step_size = st;
		r.sweep_end = sw;
		return r;
	endfunction

	initial begin
		req_t rq;
		int lens[6];
		int len_now, burst;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_sweeps = 0;
		n_taken = 0;
		foreach (lat[i]) lat[i] = '0;
		alpha_q = COEFF_RST;
		beta_q = COEFF_RST;
		step0_q = STEP_RST;
		step_q = STEP_RST;
		len_q = LEN_RST;
		acc_q = '0;
		upd_cnt = 0;
		acc_cnt = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_KINETIC;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_LEN, 24'd4);
		add_row(mk(0, 0, 0), 1'b1, rz(1'b1, STEP_RST, 1'b0));
		add_row(mk(1, 0, 16'hFFFF), 1'b1, rz(1'b1, STEP_RST, 1'b0));
		add_row(mk(1023, 0, 0), 1'b0, '0);
		add_row(mk(2, -32768, 0), 1'b0, '0);
		add_row(mk(2, 32767, 16'hFFFF), 1'b0, '0);
		add_row(mk(0, 32767, 0), 1'b0, '0);
		add_row(mk(3, -32768, 16'hFFFF), 1'b0, '0);
		add_row(mk(1, 12345, 100), 1'b0, '0);
		foreach (rows[i]) send_request(rows[i].rq, rows[i].fixed, rows[i].want, 1'b0);
		drain();
		write_reg(CFG_LEN, 24'd0);
		write_reg(CFG_KINETIC, 24'hFFFFFF);
		write_reg(CFG_POTENTIAL, 24'hFFFFFF);
		write_reg(CFG_STEP, 24'hFFFFFF);
		for (int i = 0; i < 6; i++)
			send_request(mk(i, (i % 2) ? 32767 : -32768, 16'h8000), 1'b0, '0, 1'b0);
		drain();
		write_reg(CFG_LEN, 24'h7FF);
		write_reg(CFG_KINETIC, 24'd0);
		write_reg(CFG_POTENTIAL, 24'd0);
		write_reg(CFG_STEP, 24'd0);
		for (int i = 0; i < 4; i++)
			send_request(mk(1023 - i, $urandom_range(0, 65535), 16'hFFFF), 1'b0, '0, 1'b0);
		drain();

		lens = '{2, 3, 8, 17, 64, 1024};
		for (int ph = 0; ph < 6; ph++) begin
			len_now = lens[ph];
			write_reg(CFG_LEN, 24'(len_now));
			write_reg(CFG_KINETIC, (ph == 0) ? 24'd65536 : 24'($urandom_range(1024, 400000)));
			write_reg(CFG_POTENTIAL, 24'($urandom_range(0, 300000)));
			write_reg(CFG_STEP, (ph == 3) ? 24'hFFFFFF : 24'($urandom_range(4096, 200000)));
			burst = (len_now == 1024) ? 300 : N_RANDOM / 6;
			for (int k = 0; k < burst; k++) begin
				rq.site_index = ($urandom_range(0, 15) == 0) ? 10'($urandom) :
					10'($urandom_range(0, len_now - 1));
				rq.proposal = 16'($urandom);
				rq.accept_draw = 16'($urandom);
				send_request(rq, 1'b0, '0, (k % 100) > 20);
				if (k == burst / 2) drain();
			end
			drain();
		end

		$display("covered %0d requests, %0d checked, %0d accepted, %0d sweeps", n_sent,
			n_checked, n_taken, n_sweeps);
		$display("lengths 0..2047 requested, coefficient and step extremes written");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mrlu_pkg.sv
rtl/core/mrlu_site_mem.sv
rtl/core/mrlu_step_div.sv
rtl/core/metropolis_ring_lattice_update_core.sv
rtl/core/mrlu_checker.sv
tb/sv/metropolis_ring_lattice_update_core_tb.sv
